// ===== rtl/rotate_xor_random_range_core_defines.svh =====
// Assertion macros shared by the rotate-xor random range block.
`ifndef ROTATE_XOR_RANDOM_RANGE_CORE_DEFINES_SVH
`define ROTATE_XOR_RANDOM_RANGE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RXR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RXR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rxr_pkg.sv =====
// Types, constants and the seed update function of the rotate-xor random range block.
package rxr_pkg;

    localparam int unsigned SEED_W     = 16;
    localparam int unsigned SPAN_W     = 17;
    localparam int unsigned DIVIDEND_W = 15;
    localparam int unsigned CNT_W      = 4;

    localparam logic [SEED_W-1:0] SEED_ADD   = 16'h9248;
    localparam logic [SEED_W-1:0] SEED_XOR   = 16'h9248;
    localparam logic [SEED_W-1:0] SEED_INC   = 16'h0011;
    localparam logic [CNT_W-1:0]  DIV_STEPS  = 4'd15;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    // Start request for the remainder unit.
    typedef struct packed
    {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [SPAN_W-1:0]     divisor;
    } rem_ctrl_t;

    // Add, rotate right by three, xor, add; all modulo 2^16.
    function automatic logic [SEED_W-1:0] advance_seed(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] a;
        a = s + SEED_ADD;
        a = {a[2:0], a[SEED_W-1:3]};
        a = a ^ SEED_XOR;
        a = a + SEED_INC;
        return a;
    endfunction

endpackage

// ===== rtl/rxr_rem_unit.sv =====
// Restoring remainder unit: one quotient bit per cycle over a 15-bit dividend.
module rxr_rem_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rxr_pkg::rem_ctrl_t            ctrl,
    output logic                          busy,
    output logic [rxr_pkg::SEED_W-1:0]    remainder
);
    import rxr_pkg::*;

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [SEED_W-1:0]     rem_reg;
    logic [SEED_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [SPAN_W-1:0]     div_reg;
    logic [SPAN_W-1:0]     div_next;
    logic [SPAN_W-1:0]     trial;
    logic [SPAN_W-1:0]     diff;

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

    // The partial remainder stays below the divisor, so the trial fits 17 bits.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - div_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        if (ctrl.start)
        begin
            cnt_next = DIV_STEPS;
            rem_next = '0;
            quo_next = ctrl.dividend;
            div_next = ctrl.divisor;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            if (trial >= div_reg)
            begin
                rem_next = diff[SEED_W-1:0];
            end
            else
            begin
                rem_next = trial[SEED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

// ===== rtl/rotate_xor_random_range_core.sv =====
// Top level of the rotate-xor random range generator.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: mode; tdata: seed_value, range_low, range_high
//  m_axis    out        tuser: range_error; tdata: value
//
// A load item gives no result. A draw item runs in order: the accept cycle
// advances the seed and forms the span, the restoring remainder unit then works
// one quotient bit at a time, and the last step adds the lower bound into the
// output register. Reset clears the seed to zero and leaves the block idle with
// no result pending. The input side is ready whenever no draw is in progress,
// even while a finished result still waits in the output register; a draw that
// completes while that register is still full waits until it is taken.
module rotate_xor_random_range_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // seed_value[15:0], range_low[31:16], range_high[47:32]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value[15:0]
    output logic        m_axis_tuser    // range_error
);
    import rxr_pkg::*;
    `include "rotate_xor_random_range_core_defines.svh"

    state_t            state_reg;
    state_t            state_next;
    logic [SEED_W-1:0] seed_reg;
    logic [SEED_W-1:0] seed_next;
    logic [SEED_W-1:0] lo_reg;
    logic [SEED_W-1:0] lo_next;
    logic              err_reg;
    logic              err_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SEED_W-1:0] out_value_reg;
    logic [SEED_W-1:0] out_value_next;
    logic              out_err_reg;
    logic              out_err_next;

    logic              in_accept;
    logic              out_free;
    logic [SEED_W-1:0] in_seed;
    logic [SEED_W-1:0] in_low;
    logic [SEED_W-1:0] in_high;
    logic [SEED_W-1:0] seed_adv;
    logic [SPAN_W-1:0] bound_diff;
    rem_ctrl_t         rem_ctrl;
    logic              rem_busy;
    logic [SEED_W-1:0] rem_value;

    assign in_seed = s_axis_tdata[15:0];
    assign in_low  = s_axis_tdata[31:16];
    assign in_high = s_axis_tdata[47:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_err_reg;

    assign seed_adv = advance_seed(seed_reg);

    // The bounds are sign-extended to 17 bits; a negative difference means the
    // bounds are reversed. Otherwise difference plus one is a span of 1 to 65536.
    assign bound_diff = {in_high[SEED_W-1], in_high} - {in_low[SEED_W-1], in_low};

    always_comb
    begin
        rem_ctrl.start    = in_accept && (s_axis_tuser == MODE_DRAW);
        rem_ctrl.dividend = seed_adv[DIVIDEND_W-1:0];
        rem_ctrl.divisor  = bound_diff + 1'b1;
    end

    rxr_rem_unit u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rem_ctrl),
        .busy      (rem_busy),
        .remainder (rem_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        lo_next        = lo_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == MODE_LOAD)
                    begin
                        seed_next = in_seed;
                    end
                    else
                    begin
                        seed_next  = seed_adv;
                        lo_next    = in_low;
                        err_next   = bound_diff[SPAN_W-1];
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                // Reversed bounds still run the unit; its remainder is then ignored.
                if (!rem_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = err_reg;
                    out_value_next = err_reg ? lo_reg : lo_reg + rem_value;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    // The remainder unit must be idle whenever the block takes a new item.
    `RXR_ASSERT_NOW(a_idle_unit_free, state_reg == ST_IDLE, !rem_busy, "remainder unit busy while idle")

    // A draw item starts the remainder unit in the next cycle.
    `RXR_ASSERT_NEXT(a_draw_starts, in_accept && s_axis_tuser == MODE_DRAW, state_reg == ST_DIVIDE && rem_busy, "draw did not start the remainder unit")

    // A finished draw with room at the output produces a result.
    `RXR_ASSERT_NEXT(a_draw_delivers, state_reg == ST_DIVIDE && !rem_busy && out_free, m_axis_tvalid && state_reg == ST_IDLE, "finished draw gave no result")

endmodule
